>>> hdl/tcw_pkg.sv
// Shared constants, command and status types for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 8;
  localparam int CELL_W  = 16;
  localparam int COLOUR_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

  localparam logic [CODE_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0]   SPACE_CODE   = 8'd32;
  localparam logic [COLOUR_W-1:0] BG_LIMIT     = 4'd7;

  typedef struct packed {
    logic load_item;
    logic put;
    logic newline;
    logic set_pos;
    logic read_cell;
    logic clear_step;
    logic scroll_step;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              newline;
    logic              last_row;
    logic              in_range;
    logic              sweep_last;
    logic              out_free;
  } ctl_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(r) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

>>> hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcw_dpath.sv
// Datapath: cursor, colours, screen store, sweep counter and result register.
`default_nettype none

module tcw_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tcw_pkg::ctl_cmd_t                 cmd,
  output tcw_pkg::ctl_stat_t                     stat,
  input  wire logic [tcw_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [tcw_pkg::CODE_W-1:0]        in_code,
  input  wire logic [tcw_pkg::COL_W-1:0]         in_col,
  input  wire logic [tcw_pkg::ROW_W-1:0]         in_row,
  input  wire logic                              cfg_write,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::COLOUR_W-1:0]      cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tcw_pkg::COL_W-1:0]              out_col,
  output logic [tcw_pkg::ROW_W-1:0]              out_row,
  output logic [tcw_pkg::CELL_W-1:0]             out_cell,
  output logic                                   out_accepted
);
  import tcw_pkg::*;

  logic [COLOUR_W-1:0] fg;
  logic [COLOUR_W-1:0] bg;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [KIND_W-1:0]   item_kind;
  logic [CODE_W-1:0]   item_code;
  logic [COL_W-1:0]    item_col;
  logic [ROW_W-1:0]    item_row;
  logic [ADDR_W-1:0]   sweep;
  logic                lag_valid;
  logic [ADDR_W-1:0]   lag_addr;
  logic                lag_copy;

  logic [COLOUR_W-1:0] bg_clamped;
  logic [CODE_W-1:0]   attr;
  logic                in_range;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;
  logic                sweep_copy;

  assign bg_clamped = (bg > BG_LIMIT) ? BG_LIMIT : bg;
  assign attr       = {bg_clamped, fg};
  assign in_range   = ({1'b0, item_col} < (COL_W+1)'(COLUMNS)) &&
                      ({1'b0, item_row} < (ROW_W+1)'(ROWS));
  assign sweep_copy = sweep < ADDR_W'(CELLS - COLUMNS);

  always_comb begin
    stat.kind       = item_kind;
    stat.newline    = item_code == NEWLINE_CODE;
    stat.last_row   = cur_row == ROW_W'(ROWS - 1);
    stat.in_range   = in_range;
    stat.sweep_last = sweep == ADDR_W'(CELLS - 1);
    stat.out_free   = !out_valid || out_ready;
  end

  // write port: clear sweep, delayed scroll write, or character put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(cur_row, cur_col);
    ram_wdata = {attr, item_code};
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = '0;
    end else if (lag_valid) begin
      ram_we    = 1'b1;
      ram_waddr = lag_addr;
      ram_wdata = lag_copy ? ram_rdata : {attr, SPACE_CODE};
    end else if (cmd.put) begin
      ram_we    = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = sweep + ADDR_W'(COLUMNS);
    if (cmd.read_cell) begin
      ram_re    = 1'b1;
      ram_raddr = cell_addr(item_row, item_col);
    end else if (cmd.scroll_step && sweep_copy) begin
      ram_re    = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fg        <= 4'd7;
      bg        <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      sweep     <= '0;
      lag_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_FOREGROUND) begin
        fg <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_BACKGROUND) begin
        bg <= cfg_data;
      end
      if (cmd.put && cur_col != COL_W'(COLUMNS - 1)) begin
        cur_col <= cur_col + 1'b1;
      end
      if (cmd.newline) begin
        cur_col <= '0;
        if (cur_row != ROW_W'(ROWS - 1)) begin
          cur_row <= cur_row + 1'b1;
        end
      end
      if (cmd.set_pos && in_range) begin
        cur_col <= item_col;
        cur_row <= item_row;
      end
      if (cmd.clear_step || cmd.scroll_step) begin
        sweep <= stat.sweep_last ? '0 : sweep + 1'b1;
      end
      lag_valid <= cmd.scroll_step;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= in_kind;
      item_code <= in_code;
      item_col  <= in_col;
      item_row  <= in_row;
    end
    lag_addr <= sweep;
    lag_copy <= sweep_copy;
    if (cmd.load_result) begin
      out_col      <= cur_col;
      out_row      <= cur_row;
      out_cell     <= (item_kind == KIND_READ && in_range) ? ram_rdata : '0;
      out_accepted <= (item_kind == KIND_SET || item_kind == KIND_READ) ? in_range : 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tcw_ctrl.sv
// Controller: sequences each item, the screen sweeps and the result hand-off.
`default_nettype none

module tcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tcw_pkg::ctl_stat_t stat,
  output tcw_pkg::ctl_cmd_t       cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.clear_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.kind)
          KIND_PUT: begin
            if (stat.newline) begin
              cmd.newline = 1'b1;
              state_next  = stat.last_row ? ST_SCROLL : ST_RESULT;
            end else begin
              cmd.put    = 1'b1;
              state_next = ST_RESULT;
            end
          end
          KIND_SET: begin
            cmd.set_pos = 1'b1;
            state_next  = ST_RESULT;
          end
          KIND_CLEAR: begin
            state_next = ST_CLEAR;
          end
          KIND_READ: begin
            cmd.read_cell = stat.in_range;
            state_next    = ST_READ;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/text_console_writer.sv
// Text console writer top level: stream ports, configuration port, submodules.
`default_nettype none

// An 80 x 25 character-cell console holding 16-bit cells in one RAM, with a
// cursor. Each input word is one command and returns one result word. After
// reset the block zeroes the screen RAM (one cell a cycle) with s_tready low;
// configuration writes are taken throughout. A put character, newline
// without scroll or set position passes through the execute and result
// states before the next s_tready, a read cell also through a read state
// (the RAM read is registered). A newline on the last row scrolls by copying
// the store through the single read and write port, one cell a cycle, and a
// clear zeroes one cell a cycle. The result sits in an output register, so
// the block takes the next command while it waits.
module text_console_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_code[7:0], column[14:8], row[19:15], zero pad
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                      // cell_data[27:12], accepted[28], zero pad
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import tcw_pkg::*;

  ctl_cmd_t         cmd;
  ctl_stat_t        stat;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [CELL_W-1:0] out_cell;
  logic             out_accepted;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  tcw_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (s_tuser),
    .in_code     (s_tdata[7:0]),
    .in_col      (s_tdata[14:8]),
    .in_row      (s_tdata[19:15]),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_col     (out_col),
    .out_row     (out_row),
    .out_cell    (out_cell),
    .out_accepted(out_accepted)
  );

  assign m_tdata = {3'b000, out_accepted, out_cell, out_row, out_col};

endmodule

`default_nettype wire

>>> test/text_console_writer_tb.sv
// Self-checking bench for the text console writer: directed command table, then random words.
`timescale 1ns / 100ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 68;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [COL_W-1:0]     LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic                 TYPED     = 1'b1;
  localparam logic                 PREDICTED = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] cell_data;
    logic              ok;
  } console_result_t;

  typedef struct packed {
    console_cmd_t    cmd;
    logic            typed;
    console_result_t result;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  // console image held by the predictor
  logic [CELL_W-1:0]   screen [0:CELLS-1];
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [COLOUR_W-1:0] fg_reg;
  logic [COLOUR_W-1:0] bg_reg;

  console_result_t expected_results [$];
  directed_row_t   directed_rows [$];
  console_result_t seen;
  console_result_t want;

  int mismatches = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit no_idle = 1'b0;
  int n_put = 0, n_newline = 0, n_scroll = 0, n_clear = 0, n_read = 0, n_refused = 0;
  int n_settings = 0;

  text_console_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic directed_row_t table_row(
      input logic [KIND_W-1:0] kind, input int code, input int col, input int row,
      input logic typed, input int ecol, input int erow, input int ecell, input int eok);
    directed_row_t r;
    r.cmd    = '{kind, CODE_W'(code), COL_W'(col), ROW_W'(row)};
    r.typed  = typed;
    r.result = '{COL_W'(ecol), ROW_W'(erow), CELL_W'(ecell), 1'(eok)};
    return r;
  endfunction

  function automatic console_result_t console_step(input console_cmd_t c);
    console_result_t r;
    logic [COLOUR_W-1:0] bg_used;
    logic [7:0] attr;
    int i;
    bg_used = (bg_reg > BG_LIMIT) ? BG_LIMIT : bg_reg;
    attr = {bg_used, fg_reg};
    r.cell_data = '0;
    r.ok = 1'b1;
    case (c.kind)
      KIND_PUT: begin
        if (c.code == NEWLINE_CODE) begin
          n_newline++;
          if (cur_row == LAST_ROW) begin
            n_scroll++;
            for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, SPACE_CODE};
          end else begin
            cur_row++;
          end
          cur_col = '0;
        end else begin
          n_put++;
          screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {attr, c.code};
          if (cur_col != LAST_COL) cur_col++;
        end
      end
      KIND_SET: begin
        if (int'(c.col) < COLUMNS && int'(c.row) < ROWS) begin
          cur_col = c.col;
          cur_row = c.row;
        end else begin
          r.ok = 1'b0;
        end
      end
      KIND_CLEAR: begin
        n_clear++;
        for (i = 0; i < CELLS; i++) screen[i] = '0;
      end
      default: begin
        n_read++;
        if (int'(c.col) < COLUMNS && int'(c.row) < ROWS) begin
          r.cell_data = screen[int'(c.row) * COLUMNS + int'(c.col)];
        end else begin
          r.ok = 1'b0;
        end
      end
    endcase
    if (!r.ok) n_refused++;
    r.col = cur_col;
    r.row = cur_row;
    return r;
  endfunction

  // mostly text runs and reads of written cells; positions lean towards the
  // right edge and the bottom row so that edge overwrites and scrolls occur
  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int pick;
    pick   = $urandom_range(0, 99);
    c.kind = KIND_PUT;
    c.code = CODE_W'($urandom_range(0, 255));
    c.col  = COL_W'($urandom_range(0, 127));
    c.row  = ROW_W'($urandom_range(0, 31));
    if (pick < 52) begin
      if ($urandom_range(0, 9) == 0) c.code = NEWLINE_CODE;
    end else if (pick < 67) begin
      c.kind = KIND_SET;
      if ($urandom_range(0, 4) != 0) begin
        c.col = COL_W'($urandom_range(0, COLUMNS - 1));
        c.row = ROW_W'($urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 3) == 0) c.row = LAST_ROW;
        if ($urandom_range(0, 3) == 0) c.col = COL_W'($urandom_range(COLUMNS - 3, COLUMNS - 1));
      end
    end else if (pick < 69) begin
      c.kind = KIND_CLEAR;
    end else begin
      c.kind = KIND_READ;
      if ($urandom_range(0, 6) != 0) begin
        c.row = ($urandom_range(0, 1) == 0) ? cur_row : ROW_W'($urandom_range(0, ROWS - 1));
        c.col = COL_W'($urandom_range(0, COLUMNS - 1));
        if (c.row == cur_row && $urandom_range(0, 1) == 0)
          c.col = COL_W'($urandom_range(0, int'(cur_col)));
      end
    end
    return c;
  endfunction

  task automatic send_command(input console_cmd_t c);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, c.row, c.col, c.code};
    s_tuser  <= c.kind;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
    cfg_write <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data  <= fg;
    @(posedge clk);
    fg_reg = fg;
    cfg_index <= REG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    bg_reg = bg;
    // unmapped index: must leave both colours alone
    cfg_index <= REG_SPARE;
    cfg_data  <= COLOUR_W'($urandom_range(0, 15));
    @(posedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  task automatic report_field(input string field, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, field, exp_val, got_val);
      mismatches++;
    end
  endtask

  // result side: check each word, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tdata[6:0], m_tdata[11:7], m_tdata[27:12], m_tdata[28]};
      if (expected_results.size() == 0) begin
        $display("%0t: result word 'h%0h with none expected", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        report_field("cursor_column", want.col, seen.col);
        report_field("cursor_row", want.row, seen.row);
        report_field("cell_data", want.cell_data, seen.cell_data);
        report_field("accepted", want.ok, seen.ok);
        results_checked++;
      end
    end
    if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) rx_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("[text_console_writer] ERROR");
    $finish;
  end

  initial begin
    console_cmd_t    c;
    console_result_t r;
    logic [COLOUR_W-1:0] fg, bg;
    int i, phase;

    foreach (screen[i]) screen[i] = '0;
    cur_col = '0;
    cur_row = '0;
    fg_reg  = 4'd7;
    bg_reg  = 4'd0;

    //                         kind        code  col row  check      col row cell     ok
    directed_rows.push_back(table_row(KIND_READ,  0,    0,   0, TYPED,     0,  0, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,  127,  31, TYPED,     0,  0, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_READ,  0,   80,   0, TYPED,     0,  0, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_READ,  0,   79,  24, TYPED,     0,  0, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_SET,   0,   79,  24, TYPED,    79, 24, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_SET,   0,   80,  24, TYPED,    79, 24, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_SET,   0,   79,  25, TYPED,    79, 24, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_SET,   0,  127,  31, TYPED,    79, 24, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_PUT, 'h41,   0,   0, TYPED,    79, 24, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_PUT, 'hFF, 127,  31, TYPED,    79, 24, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,   79,  24, TYPED,    79, 24, 16'h07FF, 1));
    directed_rows.push_back(table_row(KIND_PUT,  10,    0,   0, TYPED,     0, 24, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,   79,  23, TYPED,     0, 24, 16'h07FF, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,    0,  24, TYPED,     0, 24, 16'h0720, 1));
    directed_rows.push_back(table_row(KIND_PUT,   0,    0,   0, TYPED,     1, 24, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_SET,   0,    0,   0, TYPED,     0,  0, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_PUT, 'h7E,   5,   5, PREDICTED, 0,  0, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_PUT,  10,    0,   0, TYPED,     0,  1, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,    0,   0, PREDICTED, 0,  0, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_READ,  0,    0,  24, PREDICTED, 0,  0, 16'h0000, 0));
    directed_rows.push_back(table_row(KIND_CLEAR, 0,  127,  31, TYPED,     0,  1, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,    0,   0, TYPED,     0,  1, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_READ,  0,    0,  24, TYPED,     0,  1, 16'h0000, 1));
    directed_rows.push_back(table_row(KIND_PUT, 'h80,   0,   0, PREDICTED, 0,  0, 16'h0000, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++) begin
      send_command(directed_rows[i].cmd);
      r = console_step(directed_rows[i].cmd);
      expected_results.push_back(directed_rows[i].typed ? directed_rows[i].result : r);
    end
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin fg = 4'd0;  bg = 4'd0;  end
        1: begin fg = 4'd15; bg = 4'd15; end
        2: begin fg = 4'd15; bg = 4'd8;  end
        3: begin fg = 4'd0;  bg = 4'd7;  end
        default: begin
          fg = COLOUR_W'($urandom_range(0, 15));
          bg = COLOUR_W'($urandom_range(0, 15));
        end
      endcase
      write_settings(fg, bg);
      no_idle = (phase % 4 == 2);
      for (i = 0; i < PHASE_WORDS; i++) begin
        c = random_command();
        send_command(c);
        expected_results.push_back(console_step(c));
      end
      // hold the sender until every result is back
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d command words: %0d characters, %0d newlines (%0d scrolls), %0d clears,",
             directed_rows.size() + PHASES * PHASE_WORDS, n_put, n_newline, n_scroll, n_clear);
    $display("%0d reads, %0d refused; %0d results checked over %0d colour settings",
             n_read, n_refused, results_checked, n_settings);
    if (mismatches == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end

endmodule
